>>> rtl/fbpa_pkg.sv
package fbpa_pkg;

   localparam int DEFAULT_POOL_DEPTH = 1024;

   localparam int IDX_W  = 10;
   localparam int OFF_W  = 26;
   localparam int CNT_W  = 11;
   localparam int SIZE_W = 16;
   localparam int RSIZE_W = SIZE_W + 1;
   localparam int PROD_W = IDX_W + RSIZE_W;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [SIZE_W-1:0] HUNK_SIZE_RESET = SIZE_W'(4);
   localparam logic [CNT_W-1:0] POOL_HUNKS_RESET = CNT_W'(1024);

   typedef enum logic [1:0] {
      ACT_GET   = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_RESET = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EXHAUSTED  = 2'd1,
      ST_STACK_FULL = 2'd2
   } status_type;

   localparam logic CSR_HUNK_SIZE  = 1'b0;
   localparam logic CSR_POOL_HUNKS = 1'b1;

endpackage

>>> rtl/fbpa_ram.sv
module fbpa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fixed_block_pool_allocator.sv
// channel   ports                                      handshake
// request   req_action, req_hunk_index                 start && !busy
// response  rsp_status, rsp_granted_index,
//           rsp_byte_offset, rsp_active_count           rsp_strobe, one cycle
// csr       csr_index, csr_data                        csr_write
//
// one request per cycle; its response is on the rsp_ ports in the next cycle.
// the rate is set by the single registered pass: the stack top lives in a
// register and the entry under it is forwarded around the ram's registered read.
// busy stays low, there is no clearing pass; reset is synchronous, active high.
// the receiver cannot stall, each response beat lasts exactly one cycle.
module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int POOL_DEPTH = DEFAULT_POOL_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_action,
   input  logic [IDX_W-1:0]  req_hunk_index,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [IDX_W-1:0]  rsp_granted_index,
   output logic [OFF_W-1:0]  rsp_byte_offset,
   output logic [CNT_W-1:0]  rsp_active_count,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_data
);

   localparam int AW = $clog2(POOL_DEPTH);
   localparam int FW = $clog2(POOL_DEPTH + 1);
   localparam logic [FW-1:0] FULL_COUNT = FW'(POOL_DEPTH);

   logic [SIZE_W-1:0] hunk_size_ff;
   logic [CNT_W-1:0]  pool_hunks_ff;

   logic [CNT_W-1:0] bump_ff, bump_in;
   logic [FW-1:0]    free_count_ff, free_count_in;
   logic [CNT_W-1:0] in_use_ff, in_use_in;
   logic [IDX_W-1:0] top_ff, top_in;
   logic [IDX_W-1:0] sec_fwd_ff, sec_fwd_in;
   logic             use_fwd_ff, use_fwd_in;

   logic              rsp_strobe_ff;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_granted_ff, rsp_granted_in;
   logic [OFF_W-1:0]  rsp_offset_ff;
   logic [CNT_W-1:0]  rsp_active_ff;

   logic             accept;
   logic             grant_ok;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [AW-1:0]    ram_rd_addr;
   logic [IDX_W-1:0] ram_rd_data;
   logic [IDX_W-1:0] second;
   logic             bump_room;
   logic [RSIZE_W-1:0] rounded_size;
   logic [PROD_W-1:0]  product;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // entry directly under the top: forwarded copy or the ram read issued last cycle
   assign second = use_fwd_ff ? sec_fwd_ff : ram_rd_data;

   assign bump_room = (bump_ff < pool_hunks_ff) && (32'(bump_ff) < POOL_DEPTH);
   assign rounded_size = (RSIZE_W'(hunk_size_ff) + RSIZE_W'(3)) & ~RSIZE_W'(3);
   assign product = PROD_W'(rsp_granted_in) * PROD_W'(rounded_size);

   always_comb begin
      bump_in        = bump_ff;
      free_count_in  = free_count_ff;
      in_use_in      = in_use_ff;
      top_in         = top_ff;
      sec_fwd_in     = second;
      use_fwd_in     = 1'b1;
      rsp_status_in  = ST_OK;
      rsp_granted_in = '0;
      grant_ok       = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = free_count_ff[AW-1:0] - AW'(1);
      ram_rd_addr    = free_count_ff[AW-1:0] - AW'(3);
      if (accept) begin
         case (action_type'(req_action))
            ACT_GET: begin
               if (free_count_ff != '0) begin
                  // pop: the entry below becomes the top, fetch the one below that
                  grant_ok       = 1'b1;
                  rsp_granted_in = top_ff;
                  free_count_in  = free_count_ff - FW'(1);
                  top_in         = second;
                  use_fwd_in     = 1'b0;
               end else if (bump_room) begin
                  grant_ok       = 1'b1;
                  rsp_granted_in = bump_ff[IDX_W-1:0];
                  bump_in        = bump_ff + CNT_W'(1);
               end else begin
                  rsp_status_in = ST_EXHAUSTED;
               end
               if (grant_ok && in_use_ff != CNT_MAX) begin
                  in_use_in = in_use_ff + CNT_W'(1);
               end
            end
            ACT_FREE: begin
               if (free_count_ff == FULL_COUNT) begin
                  rsp_status_in = ST_STACK_FULL;
               end else begin
                  // push: old top spills into the ram and is forwarded as second
                  ram_wr_en     = (free_count_ff != '0);
                  top_in        = req_hunk_index;
                  sec_fwd_in    = top_ff;
                  free_count_in = free_count_ff + FW'(1);
                  if (in_use_ff != '0) begin
                     in_use_in = in_use_ff - CNT_W'(1);
                  end
               end
            end
            ACT_RESET: begin
               free_count_in = '0;
               bump_in       = '0;
               in_use_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   fbpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (POOL_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (top_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hunk_size_ff  <= HUNK_SIZE_RESET;
         pool_hunks_ff <= POOL_HUNKS_RESET;
         bump_ff       <= '0;
         free_count_ff <= '0;
         in_use_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_HUNK_SIZE:  hunk_size_ff  <= csr_data;
               CSR_POOL_HUNKS: pool_hunks_ff <= csr_data[CNT_W-1:0];
               default: begin
               end
            endcase
         end
         bump_ff       <= bump_in;
         free_count_ff <= free_count_in;
         in_use_ff     <= in_use_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      top_ff     <= top_in;
      sec_fwd_ff <= sec_fwd_in;
      use_fwd_ff <= use_fwd_in;
      if (accept) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_granted_ff <= rsp_granted_in;
         rsp_offset_ff  <= grant_ok ? product[OFF_W-1:0] : '0;
         rsp_active_ff  <= in_use_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_byte_offset   = rsp_offset_ff;
   assign rsp_active_count  = rsp_active_ff;

   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted request gave no response beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= FULL_COUNT)
      else $error("free stack count beyond depth");

   a_pop_grants_top: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_GET && free_count_ff != '0)
      |=> rsp_granted_index == $past(top_ff))
      else $error("pop did not grant the stack top");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_FREE && free_count_ff != FULL_COUNT)
      |=> free_count_ff == $past(free_count_ff) + FW'(1))
      else $error("push did not raise the stack count");

endmodule

>>> tb/tb.sv
module tb
   import fbpa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = DEFAULT_POOL_DEPTH;
   localparam int STALL_LIMIT = 200;
   localparam int ROUND_UP = 3;
   localparam logic [1:0] ACT_IGNORED = 2'd3;

   typedef struct {
      status_type       status;
      logic [IDX_W-1:0] index;
      logic [OFF_W-1:0] offset;
      logic [CNT_W-1:0] active;
   } grant_type;

   typedef struct {
      logic [1:0]       act;
      logic [IDX_W-1:0] idx;
      bit               typed;
      grant_type        want;
   } step_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_action = '0;
   logic [IDX_W-1:0]  req_hunk_index = '0;
   logic              rsp_strobe;
   logic [1:0]        rsp_status;
   logic [IDX_W-1:0]  rsp_granted_index;
   logic [OFF_W-1:0]  rsp_byte_offset;
   logic [CNT_W-1:0]  rsp_active_count;
   logic              csr_write = 1'b0;
   logic              csr_index = CSR_HUNK_SIZE;
   logic [SIZE_W-1:0] csr_data = '0;

   // allocator state as the testbench sees it
   logic [SIZE_W-1:0] cfg_hunk_size = HUNK_SIZE_RESET;
   logic [CNT_W-1:0]  cfg_pool_hunks = POOL_HUNKS_RESET;
   logic [IDX_W-1:0]  free_lifo [DEPTH];
   logic [CNT_W-1:0]  lifo_depth = '0;
   logic [CNT_W-1:0]  bump_ptr = '0;
   logic [CNT_W-1:0]  live_hunks = '0;

   grant_type         grants_due [$];
   logic [IDX_W-1:0]  held_hunks [$];
   int                mismatch_count = 0;
   int                idle_cycles = 0;
   bit                steady = 1'b0;

   step_type opening [20] = '{
      '{ACT_GET,     10'd0,    1'b1, '{ST_OK, 10'd0,    26'd0,    11'd1}},
      '{ACT_GET,     10'd0,    1'b1, '{ST_OK, 10'd1,    26'd4,    11'd2}},
      '{ACT_GET,     10'd1023, 1'b1, '{ST_OK, 10'd2,    26'd8,    11'd3}},
      '{ACT_FREE,    10'd1023, 1'b1, '{ST_OK, 10'd0,    26'd0,    11'd2}},
      '{ACT_GET,     10'd0,    1'b1, '{ST_OK, 10'd1023, 26'd4092, 11'd3}},
      '{ACT_IGNORED, 10'd1023, 1'b1, '{ST_OK, 10'd0,    26'd0,    11'd3}},
      '{ACT_FREE,    10'd0,    1'b1, '{ST_OK, 10'd0,    26'd0,    11'd2}},
      '{ACT_FREE,    10'd682,  1'b1, '{ST_OK, 10'd0,    26'd0,    11'd1}},
      '{ACT_FREE,    10'd341,  1'b1, '{ST_OK, 10'd0,    26'd0,    11'd0}},
      '{ACT_FREE,    10'd7,    1'b1, '{ST_OK, 10'd0,    26'd0,    11'd0}},
      '{ACT_GET,     10'd0,    1'b0, '{ST_OK, 10'd0,    26'd0,    11'd0}},
      '{ACT_GET,     10'd0,    1'b0, '{ST_OK, 10'd0,    26'd0,    11'd0}},
      '{ACT_GET,     10'd0,    1'b0, '{ST_OK, 10'd0,    26'd0,    11'd0}},
      '{ACT_GET,     10'd0,    1'b1, '{ST_OK, 10'd0,    26'd0,    11'd4}},
      '{ACT_GET,     10'd0,    1'b1, '{ST_OK, 10'd3,    26'd12,   11'd5}},
      '{ACT_RESET,   10'd1023, 1'b1, '{ST_OK, 10'd0,    26'd0,    11'd0}},
      '{ACT_GET,     10'd0,    1'b1, '{ST_OK, 10'd0,    26'd0,    11'd1}},
      '{ACT_IGNORED, 10'd0,    1'b1, '{ST_OK, 10'd0,    26'd0,    11'd1}},
      '{ACT_FREE,    10'd1,    1'b1, '{ST_OK, 10'd0,    26'd0,    11'd0}},
      '{ACT_GET,     10'd0,    1'b1, '{ST_OK, 10'd1,    26'd4,    11'd1}}
   };

   fixed_block_pool_allocator #(.POOL_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_hunk_index(req_hunk_index),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_granted_index(rsp_granted_index),
      .rsp_byte_offset(rsp_byte_offset),
      .rsp_active_count(rsp_active_count),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic grant_type grant_for(input logic [1:0] act, input logic [IDX_W-1:0] idx);
      grant_type          g;
      logic [CNT_W-1:0]   cap;
      logic [RSIZE_W-1:0] rsize;
      logic [PROD_W-1:0]  prod;
      bit                 ok;
      g.status = ST_OK;
      g.index = '0;
      g.offset = '0;
      ok = 1'b0;
      cap = (cfg_pool_hunks > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg_pool_hunks;
      rsize = (RSIZE_W'(cfg_hunk_size) + RSIZE_W'(ROUND_UP)) & ~RSIZE_W'(ROUND_UP);
      case (act)
         ACT_GET: begin
            if (lifo_depth != '0) begin
               lifo_depth = lifo_depth - CNT_W'(1);
               g.index = free_lifo[lifo_depth[IDX_W-1:0]];
               ok = 1'b1;
            end else if (bump_ptr < cap) begin
               g.index = bump_ptr[IDX_W-1:0];
               bump_ptr = bump_ptr + CNT_W'(1);
               ok = 1'b1;
            end else begin
               g.status = ST_EXHAUSTED;
            end
            if (ok) begin
               prod = PROD_W'(g.index) * PROD_W'(rsize);
               g.offset = prod[OFF_W-1:0];
               if (live_hunks != CNT_MAX) live_hunks = live_hunks + CNT_W'(1);
            end
         end
         ACT_FREE: begin
            if (lifo_depth == CNT_W'(DEPTH)) begin
               g.status = ST_STACK_FULL;
            end else begin
               free_lifo[lifo_depth[IDX_W-1:0]] = idx;
               lifo_depth = lifo_depth + CNT_W'(1);
               if (live_hunks != '0) live_hunks = live_hunks - CNT_W'(1);
            end
         end
         ACT_RESET: begin
            lifo_depth = '0;
            bump_ptr = '0;
            live_hunks = '0;
         end
         default: ;
      endcase
      g.active = live_hunks;
      return g;
   endfunction

   task automatic send_item(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                            input bit typed, input grant_type want);
      grant_type g;
      int        gap;
      if ($urandom_range(0, 31) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_hunk_index <= idx;
      do @(posedge clock); while (busy);
      g = grant_for(act, idx);
      if (act == ACT_GET && g.status == ST_OK) held_hunks.push_back(g.index);
      if (act == ACT_RESET) held_hunks.delete();
      grants_due.push_back(typed ? want : g);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (grants_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_pool(input logic [SIZE_W-1:0] size, input logic [CNT_W-1:0] hunks);
      csr_write <= 1'b1;
      csr_index <= CSR_HUNK_SIZE;
      csr_data <= size;
      @(posedge clock);
      csr_index <= CSR_POOL_HUNKS;
      csr_data <= SIZE_W'(hunks);
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_hunk_size = size;
      cfg_pool_hunks = hunks;
   endtask

   task automatic run_phase(input logic [SIZE_W-1:0] size, input logic [CNT_W-1:0] hunks,
                            input int count);
      int               r;
      int               j;
      logic [IDX_W-1:0] idx;
      wait_idle();
      program_pool(size, hunks);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         idx = IDX_W'($urandom_range(0, 1023));
         if (r < 45) begin
            send_item(ACT_GET, idx, 1'b0, '{ST_OK, '0, '0, '0});
         end else if (r < 85) begin
            // mostly give back a hunk that is really held
            if (held_hunks.size() != 0 && $urandom_range(0, 4) != 0) begin
               j = $urandom_range(0, held_hunks.size() - 1);
               idx = held_hunks[j];
               held_hunks.delete(j);
            end
            send_item(ACT_FREE, idx, 1'b0, '{ST_OK, '0, '0, '0});
         end else if (r < 93) begin
            send_item(ACT_RESET, idx, 1'b0, '{ST_OK, '0, '0, '0});
         end else begin
            send_item(ACT_IGNORED, idx, 1'b0, '{ST_OK, '0, '0, '0});
         end
      end
   endtask

   always @(posedge clock) begin
      grant_type w;
      if (!reset && rsp_strobe) begin
         if (grants_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response beat: status %0d index %0d offset %0d active %0d",
                        rsp_status, rsp_granted_index, rsp_byte_offset, rsp_active_count);
         end else begin
            w = grants_due.pop_front();
            if (rsp_status !== w.status || rsp_granted_index !== w.index ||
                rsp_byte_offset !== w.offset || rsp_active_count !== w.active) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"bad response (exp/got): status %0d/%0d index %0d/%0d ",
                            "offset %0d/%0d active %0d/%0d"},
                           w.status, rsp_status, w.index, rsp_granted_index,
                           w.offset, rsp_byte_offset, w.active, rsp_active_count);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i])
         send_item(opening[i].act, opening[i].idx, opening[i].typed, opening[i].want);

      // fill the lifo at zero count, overflow it, then pop a few off the full stack
      wait_idle();
      program_pool(16'd65535, 11'd1024);
      send_item(ACT_RESET, '0, 1'b0, '{ST_OK, '0, '0, '0});
      for (int n = 0; n < DEPTH + 1; n++)
         send_item(ACT_FREE, IDX_W'($urandom_range(0, 1023)), 1'b0, '{ST_OK, '0, '0, '0});
      for (int n = 0; n < 8; n++)
         send_item(ACT_GET, IDX_W'($urandom), 1'b0, '{ST_OK, '0, '0, '0});
      send_item(ACT_FREE, 10'd1023, 1'b0, '{ST_OK, '0, '0, '0});
      send_item(ACT_RESET, '0, 1'b0, '{ST_OK, '0, '0, '0});

      run_phase(16'd4, 11'd1024, 11);
      run_phase(16'd1, 11'd1, 11);
      run_phase(16'd0, 11'd0, 11);
      run_phase(16'd65535, 11'd2047, 11);
      run_phase(16'd3, 11'd5, 11);
      run_phase(16'd65533, 11'd1025, 11);
      run_phase(SIZE_W'($urandom_range(1, 65535)), CNT_W'($urandom_range(1, 1024)), 11);
      run_phase(16'd2, 11'd16, 11);
      run_phase(SIZE_W'($urandom_range(0, 65535)), CNT_W'($urandom_range(1, 40)), 11);

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && grants_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
